/* rtl/ctcc_pkg.sv */
// ---------------------------------------------------------------------------
// ctcc_pkg: shared types and constants of the compare timer
// Opcodes, register word map, control field positions and the request word
// that the pipeline hands to each register bank.
// ---------------------------------------------------------------------------
`default_nettype none

package ctcc_pkg;

    typedef enum logic [1:0] {
        OP_SLOW  = 2'd0,
        OP_FAST  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_opcode;

    typedef enum logic {
        BANK_CMP = 1'b0,
        BANK_CYC = 1'b1
    } t_bank;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int IRQ_W  = 4;
    localparam int PRE_W  = 8;

    // Compare timer bank word map.
    localparam logic [IDX_W-1:0] CMP_REG_STATUS = 4'd0;
    localparam logic [IDX_W-1:0] CMP_REG_CNT_LO = 4'd1;
    localparam logic [IDX_W-1:0] CMP_REG_CNT_HI = 4'd2;
    localparam int               CMP_REG_BASE   = 3;

    // Cycle counter bank word map.
    localparam logic [IDX_W-1:0] CYC_REG_LOAD    = 4'd0;
    localparam logic [IDX_W-1:0] CYC_REG_CONTROL = 4'd2;
    localparam logic [IDX_W-1:0] CYC_REG_COUNT   = 4'd8;

    localparam int CYC_ENABLE_BIT   = 9;
    localparam int CYC_PRESCALE_LSB = 16;

    typedef struct packed {
        logic              tick;
        logic              rd;
        logic              wr;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_bank_req;

endpackage

`default_nettype wire

/* rtl/ctcc_cmp_bank.sv */
// ---------------------------------------------------------------------------
// ctcc_cmp_bank: 64-bit free-running counter with compare channels
// Advances on a slow tick, sets a status bit when the new low word equals a
// channel's compare value, and clears status bits on a write of ones.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcc_cmp_bank #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ctcc_pkg::t_bank_req           i_req,
    output logic [ctcc_pkg::DATA_W-1:0]        o_rdata,
    output logic [ctcc_pkg::IRQ_W-1:0]         o_status_next
);

    localparam logic [ctcc_pkg::IRQ_W-1:0] CHAN_MASK =
        ctcc_pkg::IRQ_W'((1 << NUM_CHANNELS) - 1);

    logic [63:0]                  r_count;
    logic [63:0]                  n_count;
    logic [ctcc_pkg::DATA_W-1:0]  r_cmp [NUM_CHANNELS];
    logic [ctcc_pkg::IRQ_W-1:0]   r_status;
    logic [ctcc_pkg::IRQ_W-1:0]   n_status;
    logic [ctcc_pkg::IRQ_W-1:0]   hit;
    logic [ctcc_pkg::DATA_W-1:0]  rd_val;

    assign n_count = r_count + 64'd1;

    // Matches are taken against the low word after the increment.
    always_comb begin
        hit = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            hit[c] = (r_cmp[c] == n_count[ctcc_pkg::DATA_W-1:0]);
        end
    end

    always_comb begin
        n_status = r_status;
        if (i_req.tick) begin
            n_status = r_status | (hit & CHAN_MASK);
        end else if (i_req.wr && (i_req.idx == ctcc_pkg::CMP_REG_STATUS)) begin
            n_status = r_status & ~i_req.data[ctcc_pkg::IRQ_W-1:0];
        end
    end

    assign o_status_next = n_status;

    always_comb begin
        rd_val = '0;
        if (i_req.idx == ctcc_pkg::CMP_REG_STATUS) begin
            rd_val = {{(ctcc_pkg::DATA_W-ctcc_pkg::IRQ_W){1'b0}}, r_status};
        end else if (i_req.idx == ctcc_pkg::CMP_REG_CNT_LO) begin
            rd_val = r_count[31:0];
        end else if (i_req.idx == ctcc_pkg::CMP_REG_CNT_HI) begin
            rd_val = r_count[63:32];
        end
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (i_req.idx == ctcc_pkg::IDX_W'(ctcc_pkg::CMP_REG_BASE + c)) begin
                rd_val = r_cmp[c];
            end
        end
        o_rdata = i_req.rd ? rd_val : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_cmp[c] <= '0;
            end
        end else begin
            r_status <= n_status;
            if (i_req.tick) begin
                r_count <= n_count;
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (i_req.wr &&
                    (i_req.idx == ctcc_pkg::IDX_W'(ctcc_pkg::CMP_REG_BASE + c))) begin
                    r_cmp[c] <= i_req.data;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/ctcc_cyc_bank.sv */
// ---------------------------------------------------------------------------
// ctcc_cyc_bank: prescaled 32-bit cycle counter
// While enabled, the count advances once every prescale+1 fast ticks. The
// load word is storage only.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcc_cyc_bank (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire ctcc_pkg::t_bank_req     i_req,
    output logic [ctcc_pkg::DATA_W-1:0]  o_rdata
);

    logic [ctcc_pkg::DATA_W-1:0] r_control;
    logic [ctcc_pkg::DATA_W-1:0] r_count;
    logic [ctcc_pkg::DATA_W-1:0] r_load;
    logic [ctcc_pkg::PRE_W-1:0]  r_div;
    logic [ctcc_pkg::PRE_W-1:0]  prescale;
    logic                        enabled;
    logic                        wrap;

    assign prescale = r_control[ctcc_pkg::CYC_PRESCALE_LSB +: ctcc_pkg::PRE_W];
    assign enabled  = r_control[ctcc_pkg::CYC_ENABLE_BIT];
    // A divider at or above a lowered prescale also wraps on the next tick.
    assign wrap     = (r_div >= prescale);

    always_comb begin
        o_rdata = '0;
        if (i_req.rd) begin
            if (i_req.idx == ctcc_pkg::CYC_REG_LOAD) begin
                o_rdata = r_load;
            end else if (i_req.idx == ctcc_pkg::CYC_REG_CONTROL) begin
                o_rdata = r_control;
            end else if (i_req.idx == ctcc_pkg::CYC_REG_COUNT) begin
                o_rdata = r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_count   <= '0;
            r_load    <= '0;
            r_div     <= '0;
        end else begin
            if (i_req.tick && enabled) begin
                if (wrap) begin
                    r_div   <= '0;
                    r_count <= r_count + 32'd1;
                end else begin
                    r_div <= r_div + 8'd1;
                end
            end
            if (i_req.wr) begin
                if (i_req.idx == ctcc_pkg::CYC_REG_LOAD) begin
                    r_load <= i_req.data;
                end else if (i_req.idx == ctcc_pkg::CYC_REG_CONTROL) begin
                    r_control <= i_req.data;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/compare_timer_with_cycle_counter.sv */
// An accepted word waits in the input register, executes on the banks and its
// result goes to the result register, which drives the output port.
// Throughput: one word per cycle unless stalled; the execute path is the 64-bit
// counter increment followed by the compare of its low word with each channel.
// Reset: synchronous, active low; clears both banks, the status bits and
// the valid bits of both pipeline registers.
// ---------------------------------------------------------------------------
// compare_timer_with_cycle_counter: timer peripheral top level
// Input register, execute step on the two register banks, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module compare_timer_with_cycle_counter #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic                          i_bank,
    input  wire logic [ctcc_pkg::IDX_W-1:0]    i_reg_index,
    input  wire logic [ctcc_pkg::DATA_W-1:0]   i_write_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [ctcc_pkg::DATA_W-1:0]        o_read_data,
    output logic [ctcc_pkg::IRQ_W-1:0]         o_match_irq
);

    logic                          r_in_valid;
    ctcc_pkg::t_opcode             r_in_op;
    ctcc_pkg::t_bank               r_in_bank;
    logic [ctcc_pkg::IDX_W-1:0]    r_in_idx;
    logic [ctcc_pkg::DATA_W-1:0]   r_in_data;

    logic                          r_out_valid;
    logic [ctcc_pkg::DATA_W-1:0]   r_out_rdata;
    logic [ctcc_pkg::IRQ_W-1:0]    r_out_irq;

    logic                          exec_fire;
    logic                          in_accept;
    ctcc_pkg::t_bank_req           cmp_req;
    ctcc_pkg::t_bank_req           cyc_req;
    logic [ctcc_pkg::DATA_W-1:0]   cmp_rdata;
    logic [ctcc_pkg::DATA_W-1:0]   cyc_rdata;
    logic [ctcc_pkg::IRQ_W-1:0]    status_next;

    // The held word executes once the result register is free or draining.
    assign exec_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        cmp_req = '0;
        cyc_req = '0;
        cmp_req.idx  = r_in_idx;
        cmp_req.data = r_in_data;
        cyc_req.idx  = r_in_idx;
        cyc_req.data = r_in_data;
        if (exec_fire) begin
            unique case (r_in_op)
                ctcc_pkg::OP_SLOW: begin
                    cmp_req.tick = 1'b1;
                end
                ctcc_pkg::OP_FAST: begin
                    cyc_req.tick = 1'b1;
                end
                ctcc_pkg::OP_READ: begin
                    cmp_req.rd = (r_in_bank == ctcc_pkg::BANK_CMP);
                    cyc_req.rd = (r_in_bank == ctcc_pkg::BANK_CYC);
                end
                ctcc_pkg::OP_WRITE: begin
                    cmp_req.wr = (r_in_bank == ctcc_pkg::BANK_CMP);
                    cyc_req.wr = (r_in_bank == ctcc_pkg::BANK_CYC);
                end
                default: begin
                end
            endcase
        end
    end

    ctcc_cmp_bank #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_cmp_bank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (cmp_req),
        .o_rdata       (cmp_rdata),
        .o_status_next (status_next)
    );

    ctcc_cyc_bank u_cyc_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cyc_req),
        .o_rdata (cyc_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (exec_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= ctcc_pkg::t_opcode'(i_opcode);
            r_in_bank <= ctcc_pkg::t_bank'(i_bank);
            r_in_idx  <= i_reg_index;
            r_in_data <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Only one bank is ever read at a time, so the two read words can be ORed.
    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_rdata <= cmp_rdata | cyc_rdata;
            r_out_irq   <= status_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_rdata;
    assign o_match_irq = r_out_irq;

`ifndef SYNTHESIS
    localparam logic [ctcc_pkg::IRQ_W-1:0] IRQ_UNUSED =
        ~ctcc_pkg::IRQ_W'((1 << NUM_CHANNELS) - 1);

    a_no_irq_beyond_channels: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_match_irq & IRQ_UNUSED) == '0)
    ) else $error("status bit set for a channel that does not exist");

    a_non_read_gives_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && (r_in_op != ctcc_pkg::OP_READ)) |=> (o_read_data == '0)
    ) else $error("tick or write word returned nonzero read data");

    a_held_word_kept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_in_stall) |=>
            (r_in_valid && $stable(r_in_data) && $stable(r_in_idx))
    ) else $error("input register overwritten while waiting to execute");
`endif

endmodule

`default_nettype wire
